// ===== rtl/jre_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the Jacobi rotation engine.
// No dependencies; the multiplier, divide/square-root unit and top level import this package.
package jre_pkg;

    localparam int MAX_DIM_DEF = 16;
    localparam int ACC_W       = 67;
    localparam int OPND_W      = 33;
    localparam int PROD_W      = 66;
    localparam int PADDR_W     = 3;

    localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;
    localparam logic [4:0] SIZE_RESET      = 5'd16;

    localparam logic [2:0] OP_WRITE_A = 3'd0;
    localparam logic [2:0] OP_WRITE_R = 3'd1;
    localparam logic [2:0] OP_ROTATE  = 3'd2;
    localparam logic [2:0] OP_READ_A  = 3'd3;
    localparam logic [2:0] OP_READ_R  = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_PIVOT = 2'd2;

    localparam logic signed [OPND_W-1:0] Q30_ONE = 33'sd1073741824;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_READ, ST_RD_LL, ST_RD_KL, ST_PIV, ST_HD,
        ST_MAC, ST_POST, ST_UNIT, ST_ZKL, ST_ZLK, ST_ROW, ST_AR1, ST_AR2,
        ST_AW1, ST_AW2, ST_RR0, ST_RR1, ST_RR2, ST_DONE
    } t_state;

    // multiply-accumulate jobs run on the shared multiplier
    typedef enum logic [3:0] {
        J_HHDD, J_TT, J_CT, J_CC, J_SS, J_CS, J_DKK, J_DLL,
        J_AK, J_AL, J_RK, J_RL
    } t_job;

    typedef enum logic [1:0] {U_ROOT1, U_TAN, U_ROOT2, U_COS} t_utag;

    typedef enum logic {UM_DIV, UM_SQRT} t_umode;

    typedef struct packed {
        logic        start;
        t_umode      mode;
        logic [63:0] num;
        logic [32:0] den;
    } t_unit_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] q;
    } t_unit_rsp;

    // arithmetic shift by 30 that truncates toward zero
    function automatic logic signed [ACC_W-1:0] shr30(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] mag;
        begin
            mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
            mag = mag >> 30;
            shr30 = v[ACC_W-1] ? -$signed(mag) : $signed(mag);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        begin
            if (v > 67'sd2147483647) begin
                sat32 = 32'sh7fffffff;
            end else if (v < -67'sd2147483648) begin
                sat32 = 32'sh80000000;
            end else begin
                sat32 = v[31:0];
            end
        end
    endfunction

endpackage

// ===== rtl/jre_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the Jacobi rotation engine.
// Command channel and result channel; no package dependency.
interface jre_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [3:0]  row;
    logic [3:0]  col;
    logic signed [31:0] write_value;

    modport source (output valid, opcode, row, col, write_value, input ready);
    modport sink   (input valid, opcode, row, col, write_value, output ready);
endinterface

interface jre_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] read_value;
    logic [1:0]  status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

// ===== rtl/jre_mul.sv =====
`timescale 1ns / 1ps
// Shared signed 33x33 multiplier with a registered product.
// Depends on jre_pkg for operand and product widths.
module jre_mul import jre_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [OPND_W-1:0] i_a,
    input  logic signed [OPND_W-1:0] i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== rtl/jre_divsqrt.sv =====
`timescale 1ns / 1ps
// Shared shift-subtract unit: 64/33 unsigned divide or 64-bit integer square root.
// Depends on jre_pkg for the request and response structs.
module jre_divsqrt import jre_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_unit_req i_req,
    output t_unit_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    t_umode      r_mode;
    logic [5:0]  r_cnt;
    logic [63:0] r_x;
    logic [63:0] r_q;
    logic [35:0] r_rem;
    logic [32:0] r_den;

    logic [35:0] shifted;
    logic [35:0] trial;
    logic        ge;

    always_comb begin
        if (r_mode == UM_DIV) begin
            shifted = {r_rem[34:0], r_x[63]};
            trial   = {3'b000, r_den};
        end else begin
            shifted = {r_rem[33:0], r_x[63:62]};
            trial   = {r_q[33:0], 2'b01};
        end
        ge = (shifted >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_mode <= UM_DIV;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_mode <= i_req.mode;
                r_cnt  <= (i_req.mode == UM_DIV) ? 6'd63 : 6'd31;
                r_x    <= i_req.num;
                r_q    <= '0;
                r_rem  <= '0;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_x   <= (r_mode == UM_DIV) ? {r_x[62:0], 1'b0} : {r_x[61:0], 2'b00};
                r_rem <= ge ? (shifted - trial) : shifted;
                r_q   <= {r_q[62:0], ge};
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("unit started while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("unit done while still busy");
    a_sqrt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_mode == UM_SQRT) |-> (r_cnt <= 6'd31))
        else $error("square root ran past its step count");

endmodule

// ===== rtl/jacobi_rotation_engine_core.sv =====
`timescale 1ns / 1ps
// Jacobi rotation engine top level: matrix stores, sequencer, APB config port.
// Depends on jre_pkg, jre_if, jre_mul and jre_divsqrt.
// Path from accept to result register: writes, flagged and unknown opcodes finish after
// decode, reads add a memory read; rotations run two 32-step roots and two 64-step divides
// on the shared unit (skipped if A(k,l) is zero), then update each row of the active size.
// Throughput: one transaction at a time; ready returns once the result is registered.
// Reset (synchronous, active low) clears the sequencer, empties the result register and
// sets matrix_size to 16; matrix contents are undefined until written.
module jacobi_rotation_engine_core import jre_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    jre_in_if.sink             i_in,
    jre_out_if.source          o_out
);

    localparam int IW    = $clog2(MAX_DIM);
    localparam int AW    = 2 * IW;
    localparam int NW    = $clog2(MAX_DIM + 1);
    localparam int DEPTH = 1 << AW;

    // sequencer and transaction registers
    t_state r_state, n_state;
    logic [2:0]  r_op;
    logic [1:0]  r_stat;
    logic signed [31:0] r_wval;
    logic [IW-1:0] r_k, r_l, r_i;
    logic [4:0]  r_size;
    logic [NW-1:0] act_n;

    // rotation data path registers
    logic signed [31:0] r_akk, r_all, r_akl, r_x, r_y, r_wv;
    logic [31:0] r_h, r_d;
    logic        r_neg;
    logic [30:0] r_t, r_cm;
    logic signed [OPND_W-1:0] r_c, r_s, r_c2, r_s2, r_cs2;
    t_job  r_job;
    logic [1:0] r_step;
    t_utag r_tag;
    logic signed [ACC_W-1:0] r_acc;

    // result staging and output register
    logic signed [31:0] r_res_rd;
    logic [1:0]  r_res_st;
    logic        r_out_valid;
    logic signed [31:0] r_out_rd;
    logic [1:0]  r_out_st;

    // matrix stores
    logic signed [31:0] r_mem_a [DEPTH];
    logic signed [31:0] r_mem_r [DEPTH];
    logic signed [31:0] r_a_rd, r_r_rd;

    logic [AW-1:0] a_raddr, a_waddr, rm_raddr, rm_waddr;
    logic          a_we, rm_we;
    logic signed [31:0] a_wdata, rm_wdata;

    logic signed [OPND_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [ACC_W-1:0]  prod_ext, acc_shr, acc2_shr;
    logic signed [31:0] post_val;

    t_unit_req unit_req;
    t_unit_rsp unit_rsp;

    logic        in_acc;
    logic [1:0]  acc_stat;
    logic [1:0]  job_terms;
    logic        term_neg;
    logic        skip_a, last_row;
    logic signed [32:0] piv_num, piv_abs, akl_ext, akl_abs;
    logic        cfg_wr;

    jre_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    jre_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .o_rsp   (unit_rsp)
    );

    // active size: matrix_size clamped to [2, MAX_DIM]
    always_comb begin
        if (r_size < 5'd2) begin
            act_n = NW'(2);
        end else if (32'(r_size) > MAX_DIM) begin
            act_n = NW'(MAX_DIM);
        end else begin
            act_n = NW'(r_size);
        end
    end

    assign in_acc = i_in.valid & i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // range check comes before the equal-pivot check; unknown opcodes are ok
    always_comb begin
        acc_stat = STAT_OK;
        if (i_in.opcode <= OP_READ_R) begin
            if (32'(i_in.row) >= 32'(act_n) || 32'(i_in.col) >= 32'(act_n)) begin
                acc_stat = STAT_RANGE;
            end else if (i_in.opcode == OP_ROTATE && i_in.row == i_in.col) begin
                acc_stat = STAT_PIVOT;
            end
        end
    end

    // config port: single register, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_MATRIX_SIZE);
    assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? {27'd0, r_size} : 32'd0;

    // pivot preprocessing
    assign piv_num  = {r_all[31], r_all} - {r_akk[31], r_akk};
    assign piv_abs  = piv_num[32] ? -piv_num : piv_num;
    assign akl_ext  = {r_akl[31], r_akl};
    assign akl_abs  = akl_ext[32] ? -akl_ext : akl_ext;

    assign prod_ext = ACC_W'(mul_p);
    assign acc_shr  = shr30(r_acc);
    assign acc2_shr = shr30(r_acc <<< 1);
    assign post_val = sat32(acc_shr);

    assign skip_a   = (r_i == r_k) || (r_i == r_l);
    assign last_row = (32'(r_i) == 32'(act_n) - 32'd1);

    always_comb begin
        unique case (r_job)
            J_DKK, J_DLL:               job_terms = 2'd3;
            J_HHDD, J_AK, J_AL, J_RK, J_RL: job_terms = 2'd2;
            default:                    job_terms = 2'd1;
        endcase
    end

    // only the second term of the k-side updates is subtracted
    assign term_neg = (r_step == 2'd2) &&
                      (r_job == J_DKK || r_job == J_AK || r_job == J_RK);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_acc) n_state = ST_DECODE;
            ST_DECODE: begin
                priority if (r_stat != STAT_OK || r_op > OP_READ_R) n_state = ST_DONE;
                else if (r_op == OP_READ_A || r_op == OP_READ_R) n_state = ST_READ;
                else if (r_op == OP_ROTATE) n_state = ST_RD_LL;
                else n_state = ST_DONE;
            end
            ST_READ:   n_state = ST_DONE;
            ST_RD_LL:  n_state = ST_RD_KL;
            ST_RD_KL:  n_state = ST_PIV;
            ST_PIV:    n_state = ST_HD;
            ST_HD:     n_state = ST_MAC;
            ST_MAC:    if (r_step == job_terms) n_state = ST_POST;
            ST_POST: begin
                unique case (r_job)
                    J_HHDD, J_TT: n_state = ST_UNIT;
                    J_DLL:        n_state = ST_ZKL;
                    J_AK:         n_state = ST_AW1;
                    J_AL:         n_state = ST_AW2;
                    J_RL:         n_state = last_row ? ST_DONE : ST_ROW;
                    default:      n_state = ST_MAC;
                endcase
            end
            ST_UNIT: begin
                if (unit_rsp.done) begin
                    n_state = (r_tag == U_ROOT1 || r_tag == U_ROOT2) ? ST_UNIT : ST_MAC;
                end
            end
            ST_ZKL:    n_state = ST_ZLK;
            ST_ZLK:    n_state = ST_ROW;
            ST_ROW:    n_state = skip_a ? ST_RR0 : ST_AR1;
            ST_AR1:    n_state = ST_AR2;
            ST_AR2:    n_state = ST_MAC;
            ST_AW1:    n_state = ST_MAC;
            ST_AW2:    n_state = ST_RR0;
            ST_RR0:    n_state = ST_RR1;
            ST_RR1:    n_state = ST_RR2;
            ST_RR2:    n_state = ST_MAC;
            ST_DONE:   if (!r_out_valid || o_out.ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: memory ports, multiplier operands, unit requests
    always_comb begin
        a_raddr  = {r_k, r_l};
        rm_raddr = {r_k, r_l};
        a_we     = 1'b0;
        a_waddr  = {r_k, r_l};
        a_wdata  = r_wval;
        rm_we    = 1'b0;
        rm_waddr = {r_k, r_l};
        rm_wdata = r_wval;
        mul_a    = '0;
        mul_b    = '0;
        unit_req.start = 1'b0;
        unit_req.mode  = UM_DIV;
        unit_req.num   = '0;
        unit_req.den   = '0;
        unique case (r_state)
            ST_DECODE: begin
                if (r_op == OP_ROTATE) a_raddr = {r_k, r_k};
                a_we  = (r_op == OP_WRITE_A) && (r_stat == STAT_OK);
                rm_we = (r_op == OP_WRITE_R) && (r_stat == STAT_OK);
            end
            ST_RD_LL: a_raddr = {r_l, r_l};
            ST_RD_KL: a_raddr = {r_k, r_l};
            ST_MAC: begin
                unique case (r_job)
                    J_HHDD: begin
                        mul_a = (r_step == 2'd0) ? {1'b0, r_h} : {1'b0, r_d};
                        mul_b = mul_a;
                    end
                    J_TT: begin
                        mul_a = {2'b00, r_t};
                        mul_b = {2'b00, r_t};
                    end
                    J_CT: begin
                        mul_a = {2'b00, r_cm};
                        mul_b = {2'b00, r_t};
                    end
                    J_CC: begin
                        mul_a = r_c;
                        mul_b = r_c;
                    end
                    J_SS: begin
                        mul_a = r_s;
                        mul_b = r_s;
                    end
                    J_CS: begin
                        mul_a = r_c;
                        mul_b = r_s;
                    end
                    J_DKK, J_DLL: begin
                        unique case (r_step)
                            2'd0: begin
                                mul_a = (r_job == J_DKK) ? r_c2 : r_s2;
                                mul_b = {r_akk[31], r_akk};
                            end
                            2'd1: begin
                                mul_a = r_cs2;
                                mul_b = akl_ext;
                            end
                            2'd2: begin
                                mul_a = (r_job == J_DKK) ? r_s2 : r_c2;
                                mul_b = {r_all[31], r_all};
                            end
                            default: begin
                                mul_a = '0;
                                mul_b = '0;
                            end
                        endcase
                    end
                    J_AK, J_RK: begin
                        mul_a = (r_step == 2'd0) ? r_c : r_s;
                        mul_b = (r_step == 2'd0) ? {r_x[31], r_x} : {r_y[31], r_y};
                    end
                    J_AL, J_RL: begin
                        mul_a = (r_step == 2'd0) ? r_c : r_s;
                        mul_b = (r_step == 2'd0) ? {r_y[31], r_y} : {r_x[31], r_x};
                    end
                    default: ;
                endcase
            end
            ST_POST: begin
                unique case (r_job)
                    J_HHDD: begin
                        unit_req.start = 1'b1;
                        unit_req.mode  = UM_SQRT;
                        unit_req.num   = r_acc[63:0];
                    end
                    J_TT: begin
                        unit_req.start = 1'b1;
                        unit_req.mode  = UM_SQRT;
                        unit_req.num   = 64'h1000_0000_0000_0000 + r_acc[63:0];
                    end
                    J_DKK: begin
                        a_we    = 1'b1;
                        a_waddr = {r_k, r_k};
                        a_wdata = post_val;
                    end
                    J_DLL: begin
                        a_we    = 1'b1;
                        a_waddr = {r_l, r_l};
                        a_wdata = post_val;
                    end
                    J_AK: begin
                        a_we    = 1'b1;
                        a_waddr = {r_i, r_k};
                        a_wdata = post_val;
                    end
                    J_AL: begin
                        a_we    = 1'b1;
                        a_waddr = {r_i, r_l};
                        a_wdata = post_val;
                    end
                    J_RK: begin
                        rm_we    = 1'b1;
                        rm_waddr = {r_i, r_k};
                        rm_wdata = post_val;
                    end
                    J_RL: begin
                        rm_we    = 1'b1;
                        rm_waddr = {r_i, r_l};
                        rm_wdata = post_val;
                    end
                    default: ;
                endcase
            end
            ST_UNIT: begin
                // chain the divide straight off the finished root
                if (unit_rsp.done && r_tag == U_ROOT1) begin
                    unit_req.start = 1'b1;
                    unit_req.mode  = UM_DIV;
                    unit_req.num   = {2'b00, r_d, 30'd0};
                    unit_req.den   = {1'b0, unit_rsp.q[31:0]} + {1'b0, r_h};
                end else if (unit_rsp.done && r_tag == U_ROOT2) begin
                    unit_req.start = 1'b1;
                    unit_req.mode  = UM_DIV;
                    unit_req.num   = 64'h1000_0000_0000_0000;
                    unit_req.den   = {1'b0, unit_rsp.q[31:0]};
                end
            end
            ST_ZKL: begin
                a_we    = 1'b1;
                a_waddr = {r_k, r_l};
                a_wdata = '0;
            end
            ST_ZLK: begin
                a_we    = 1'b1;
                a_waddr = {r_l, r_k};
                a_wdata = '0;
            end
            ST_ROW: a_raddr = {r_i, r_k};
            ST_AR1: a_raddr = {r_i, r_l};
            ST_AW1: begin
                a_we    = 1'b1;
                a_waddr = {r_k, r_i};
                a_wdata = r_wv;
            end
            ST_AW2: begin
                a_we    = 1'b1;
                a_waddr = {r_l, r_i};
                a_wdata = r_wv;
            end
            ST_RR0: rm_raddr = {r_i, r_k};
            ST_RR1: rm_raddr = {r_i, r_l};
            default: ;
        endcase
    end

    // matrix stores: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (a_we) begin
            r_mem_a[a_waddr] <= a_wdata;
        end
        r_a_rd <= r_mem_a[a_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rm_we) begin
            r_mem_r[rm_waddr] <= rm_wdata;
        end
        r_r_rd <= r_mem_r[rm_raddr];
    end

    // control registers, output register and data path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_size      <= SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_size <= pwdata[4:0];
            end
            // load the result register when it is free or being drained
            if (r_state == ST_DONE && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
                r_out_rd    <= r_res_rd;
                r_out_st    <= r_res_st;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_op   <= i_in.opcode;
                        r_stat <= acc_stat;
                        r_wval <= i_in.write_value;
                        r_k    <= IW'(i_in.row);
                        r_l    <= IW'(i_in.col);
                    end
                end
                ST_DECODE: begin
                    r_res_rd <= '0;
                    r_res_st <= r_stat;
                end
                ST_READ:  r_res_rd <= (r_op == OP_READ_A) ? r_a_rd : r_r_rd;
                ST_RD_LL: r_akk <= r_a_rd;
                ST_RD_KL: r_all <= r_a_rd;
                ST_PIV:   r_akl <= r_a_rd;
                ST_HD: begin
                    r_step <= 2'd0;
                    if (r_akl == 32'sd0) begin
                        r_c   <= Q30_ONE;
                        r_s   <= '0;
                        r_job <= J_CC;
                    end else begin
                        r_h   <= piv_abs[32:1];
                        r_d   <= akl_abs[31:0];
                        r_neg <= (piv_num == 33'sd0) || (piv_num[32] != r_akl[31]);
                        r_job <= J_HHDD;
                    end
                end
                ST_MAC: begin
                    r_step <= r_step + 2'd1;
                    if (r_step != 2'd0) begin
                        r_acc <= ((r_step == 2'd1) ? '0 : r_acc) +
                                 (term_neg ? -prod_ext : prod_ext);
                    end
                end
                ST_POST: begin
                    r_step <= 2'd0;
                    unique case (r_job)
                        J_HHDD: r_tag <= U_ROOT1;
                        J_TT:   r_tag <= U_ROOT2;
                        J_CT: begin
                            r_c   <= {2'b00, r_cm};
                            r_s   <= r_neg ? -acc_shr[32:0] : acc_shr[32:0];
                            r_job <= J_CC;
                        end
                        J_CC: begin
                            r_c2  <= acc_shr[32:0];
                            r_job <= J_SS;
                        end
                        J_SS: begin
                            r_s2  <= acc_shr[32:0];
                            r_job <= J_CS;
                        end
                        J_CS: begin
                            r_cs2 <= acc2_shr[32:0];
                            r_job <= J_DKK;
                        end
                        J_DKK:  r_job <= J_DLL;
                        J_DLL:  r_i <= '0;
                        J_AK:   r_wv <= post_val;
                        J_AL:   r_wv <= post_val;
                        J_RK:   r_job <= J_RL;
                        J_RL:   r_i <= r_i + IW'(1);
                        default: ;
                    endcase
                end
                ST_UNIT: begin
                    if (unit_rsp.done) begin
                        r_step <= 2'd0;
                        unique case (r_tag)
                            U_ROOT1: r_tag <= U_TAN;
                            U_TAN: begin
                                r_t   <= unit_rsp.q[30:0];
                                r_job <= J_TT;
                            end
                            U_ROOT2: r_tag <= U_COS;
                            U_COS: begin
                                r_cm  <= unit_rsp.q[30:0];
                                r_job <= J_CT;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_AR1: r_x <= r_a_rd;
                ST_AR2: begin
                    r_y    <= r_a_rd;
                    r_job  <= J_AK;
                    r_step <= 2'd0;
                end
                ST_AW1: begin
                    r_job  <= J_AL;
                    r_step <= 2'd0;
                end
                ST_RR1: r_x <= r_r_rd;
                ST_RR2: begin
                    r_y    <= r_r_rd;
                    r_job  <= J_RK;
                    r_step <= 2'd0;
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_value = r_out_rd;
    assign o_out.status     = r_out_st;

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_DECODE)) else $error("accepted transaction not decoded");
    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_st != STAT_OK) |-> (r_out_rd == 32'sd0))
        else $error("flagged result carries data");
    a_err_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECODE && (a_we || rm_we)) |-> (r_stat == STAT_OK))
        else $error("flagged transaction wrote a matrix");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROW) |-> (32'(r_i) < 32'(act_n)))
        else $error("row sweep ran past the active size");

endmodule
